// ===== src/aps_pkg.sv =====
// Shared types, codes and saturation helpers for the aging priority scheduler.
package aps_pkg;

	// Default table size and fixed field widths
	localparam int SLOTS_DEF  = 4;
	localparam int PRIO_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Request operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Slot run states
	localparam logic [1:0] ST_INACTIVE = 2'd0;
	localparam logic [1:0] ST_READY    = 2'd1;
	localparam logic [1:0] ST_FINISHED = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AGING_STEP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_PENALTY = 1'b1;

	// Configuration reset values
	localparam logic [CFG_DATA_W-1:0] AGING_STEP_RST  = 8'd1;
	localparam logic [CFG_DATA_W-1:0] RUN_PENALTY_RST = 8'd3;

	localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7fff;
	localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

	typedef struct packed {
		logic               operation;
		logic [1:0]         slot_index;
		logic [15:0]        task_id;
		logic signed [15:0] priority_req;
		logic [1:0]         run_state;
		logic [15:0]        quanta;
	} req_t;

	typedef struct packed {
		logic               picked;
		logic [1:0]         picked_slot;
		logic [15:0]        picked_id;
		logic signed [15:0] picked_priority;
		logic [15:0]        picked_left;
		logic               all_done;
	} rsp_t;

	// Clamp a 17-bit signed sum to the 16-bit signed range
	function automatic logic signed [PRIO_W-1:0] sat_prio(input logic signed [PRIO_W:0] v);
		logic signed [PRIO_W-1:0] r;
		if (v[PRIO_W] != v[PRIO_W-1]) begin
			r = v[PRIO_W] ? PRIO_MIN : PRIO_MAX;
		end else begin
			r = v[PRIO_W-1:0];
		end
		return r;
	endfunction

	// Priority raised by the aging step, saturated
	function automatic logic signed [PRIO_W-1:0] prio_age(
		input logic signed [PRIO_W-1:0] p,
		input logic [CFG_DATA_W-1:0]    step
	);
		logic signed [PRIO_W:0] s;
		s = $signed({p[PRIO_W-1], p}) + $signed({{(PRIO_W+1-CFG_DATA_W){1'b0}}, step});
		return sat_prio(s);
	endfunction

	// Priority lowered by the run penalty, saturated
	function automatic logic signed [PRIO_W-1:0] prio_charge(
		input logic signed [PRIO_W-1:0] p,
		input logic [CFG_DATA_W-1:0]    pen
	);
		logic signed [PRIO_W:0] s;
		s = $signed({p[PRIO_W-1], p}) - $signed({{(PRIO_W+1-CFG_DATA_W){1'b0}}, pen});
		return sat_prio(s);
	endfunction

endpackage

// ===== src/aps_pick_tree.sv =====
// Tournament compare tree that selects the highest-priority candidate slot.
module aps_pick_tree import aps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                       cand  [SLOTS],
	input  logic signed [PRIO_W-1:0]   prio  [SLOTS],
	output logic                       found,
	output logic [$clog2(SLOTS)-1:0]   idx
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int LEAVES = 1 << IDX_W;

	logic                     node_v [2*LEAVES];
	logic signed [PRIO_W-1:0] node_p [2*LEAVES];
	logic [IDX_W-1:0]         node_i [2*LEAVES];

	// Node zero is unused; tie it off
	assign node_v[0] = 1'b0;
	assign node_p[0] = '0;
	assign node_i[0] = '0;

	// Fill the leaves; padding leaves never win
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < SLOTS) begin : g_used
			assign node_v[LEAVES+j] = cand[j];
			assign node_p[LEAVES+j] = prio[j];
		end else begin : g_pad
			assign node_v[LEAVES+j] = 1'b0;
			assign node_p[LEAVES+j] = '0;
		end
		assign node_i[LEAVES+j] = IDX_W'(j);
	end

	// Merge pairs; the left (lower index) side wins a tie
	for (genvar n = 1; n < LEAVES; n++) begin : g_node
		logic take_left;
		assign take_left = node_v[2*n] &&
			(!node_v[2*n+1] || (node_p[2*n] >= node_p[2*n+1]));
		assign node_v[n] = node_v[2*n] || node_v[2*n+1];
		assign node_p[n] = take_left ? node_p[2*n] : node_p[2*n+1];
		assign node_i[n] = take_left ? node_i[2*n] : node_i[2*n+1];
	end

	assign found = node_v[1];
	assign idx   = node_i[1];

endmodule

// ===== src/aps_slot_table.sv =====
// Task slot table with load, pick, charge and aging update in one pass.
module aps_slot_table import aps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_en,
	input  req_t                  item,
	input  logic [CFG_DATA_W-1:0] aging_step,
	input  logic [CFG_DATA_W-1:0] run_penalty,
	output rsp_t                  result
);

	localparam int IDX_W = $clog2(SLOTS);

	logic [15:0]              ids_q      [SLOTS];
	logic signed [PRIO_W-1:0] prio_q     [SLOTS];
	logic [1:0]               state_q    [SLOTS];
	logic [15:0]              quanta_q   [SLOTS];

	logic [15:0]              ids_nxt    [SLOTS];
	logic signed [PRIO_W-1:0] prio_nxt   [SLOTS];
	logic [1:0]               state_nxt  [SLOTS];
	logic [15:0]              quanta_nxt [SLOTS];

	logic                     cand       [SLOTS];
	logic                     found;
	logic [IDX_W-1:0]         pick_idx;
	logic                     run;
	logic [IDX_W+1:0]         pick_ext;
	logic                     any_left;

	// Mark slots eligible to run: ready, time left, priority above zero
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			cand[i] = (state_q[i] == ST_READY) && (quanta_q[i] != 16'd0) &&
				(prio_q[i] > 16'sd0);
		end
	end

	aps_pick_tree #(
		.SLOTS (SLOTS)
	) u_pick (
		.cand  (cand),
		.prio  (prio_q),
		.found (found),
		.idx   (pick_idx)
	);

	assign run = (item.operation == OP_TICK) && found;

	// Compute the table after this request
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			ids_nxt[i]    = ids_q[i];
			prio_nxt[i]   = prio_q[i];
			state_nxt[i]  = state_q[i];
			quanta_nxt[i] = quanta_q[i];
			if (item.operation == OP_LOAD) begin
				if (int'(item.slot_index) == i) begin
					ids_nxt[i]    = item.task_id;
					prio_nxt[i]   = item.priority_req;
					state_nxt[i]  = item.run_state;
					quanta_nxt[i] = item.quanta;
				end
			end else if (run && (int'(pick_idx) == i)) begin
				prio_nxt[i]   = prio_charge(prio_q[i], run_penalty);
				quanta_nxt[i] = quanta_q[i] - 16'd1;
				state_nxt[i]  = (quanta_q[i] == 16'd1) ? ST_FINISHED : ST_READY;
			end else if (state_q[i] == ST_READY) begin
				prio_nxt[i] = prio_age(prio_q[i], aging_step);
			end
		end
	end

	// Check whether any slot still holds time
	always_comb begin
		any_left = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			any_left = any_left | (quanta_nxt[i] != 16'd0);
		end
	end

	// Build the result for this request
	assign pick_ext = (IDX_W+2)'(pick_idx);

	always_comb begin
		result = '0;
		if (run) begin
			result.picked          = 1'b1;
			result.picked_slot     = pick_ext[1:0];
			result.picked_id       = ids_q[pick_idx];
			result.picked_priority = prio_nxt[pick_idx];
			result.picked_left     = quanta_nxt[pick_idx];
		end
		result.all_done = !any_left;
	end

	// Commit the table when the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ids_q[i]    <= '0;
				prio_q[i]   <= '0;
				state_q[i]  <= ST_INACTIVE;
				quanta_q[i] <= '0;
			end
		end else if (item_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				ids_q[i]    <= ids_nxt[i];
				prio_q[i]   <= prio_nxt[i];
				state_q[i]  <= state_nxt[i];
				quanta_q[i] <= quanta_nxt[i];
			end
		end
	end

endmodule

// ===== src/aging_priority_scheduler.sv =====
// Top level of the aging priority scheduler: request/response registers and configuration.
//
// Usage:
//   Requests enter on req_valid/req_data and are taken at a clock edge where
//   req_valid is high and req_stall is low. Operation load writes one slot;
//   operation tick picks the highest-priority ready slot, charges it one
//   quantum and the run penalty, and ages every other ready slot.
//   Every request yields exactly one response on rsp_valid/rsp_data, taken
//   at an edge where rsp_valid is high and rsp_stall is low.
//   A request taken into the request register is presented as a response once
//   it moves on into the response register. Throughput: one request per cycle
//   unless a held response is stalled; the pick tree and the slot update are
//   combinational between the two registers; the table writes as the response loads.
//   When the receiver stalls with a response held, the request register
//   still takes one more request; after that req_stall rises until the
//   response is taken.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (aging_step, run_penalty) at the clock edge; write only while idle.
//   Reset: all slots clear to inactive with zero id, priority and time;
//   aging_step resets to 1 and run_penalty to 3; no response is pending.
module aging_priority_scheduler import aps_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                  valid_s1;
	req_t                  data_s1;
	logic                  rsp_valid_q;
	rsp_t                  rsp_data_q;
	logic [CFG_DATA_W-1:0] aging_step_q;
	logic [CFG_DATA_W-1:0] run_penalty_q;
	logic                  advance;
	logic                  req_take;
	rsp_t                  result;

	// Advance when the response register is free or being drained
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	// Hold the request in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			data_s1 <= req_data;
		end
	end

	aps_slot_table #(
		.SLOTS (SLOTS)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_en     (valid_s1 && advance),
		.item        (data_s1),
		.aging_step  (aging_step_q),
		.run_penalty (run_penalty_q),
		.result      (result)
	);

	// Register the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_data_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_step_q  <= AGING_STEP_RST;
			run_penalty_q <= RUN_PENALTY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_AGING_STEP:  aging_step_q  <= cfg_wdata;
				CFG_RUN_PENALTY: run_penalty_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the aging priority scheduler: stimulus, slot table predictor, checker.
module tb_top;
	import aps_pkg::*;

	localparam int SLOT_N       = SLOTS_DEF;
	localparam int LIMIT_CYCLES = 200000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req_data  = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	aging_priority_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Predicted slot table and registers
	logic [15:0]        tbl_id     [SLOT_N];
	logic signed [15:0] tbl_prio   [SLOT_N];
	logic [1:0]         tbl_state  [SLOT_N];
	logic [15:0]        tbl_quanta [SLOT_N];
	logic [7:0]         age_step;
	logic [7:0]         run_pen;

	req_t req_backlog [$];
	rsp_t grant_queue [$];
	rsp_t want;

	int  n_issued    = 0;
	int  n_answered  = 0;
	int  n_errors    = 0;
	int  cycle_count = 0;
	int  send_gap    = 0;
	int  stall_left  = 0;
	bit  drain_hold  = 1'b0;
	bit  quiet       = 1'b0;
	logic req_fired  = 1'b0;

	function automatic void slots_clear();
		for (int k = 0; k < SLOT_N; k++) begin
			tbl_id[k]     = '0;
			tbl_prio[k]   = '0;
			tbl_state[k]  = ST_INACTIVE;
			tbl_quanta[k] = '0;
		end
		age_step = AGING_STEP_RST;
		run_pen  = RUN_PENALTY_RST;
	endfunction

	function automatic logic signed [15:0] clamp_prio(int v);
		if (v > 32767) return PRIO_MAX;
		if (v < -32768) return PRIO_MIN;
		return v[15:0];
	endfunction

	// Apply one request to the predicted table and return the response it yields
	function automatic rsp_t predict_grant(req_t r);
		rsp_t o;
		int   best;
		int   best_p;
		o = '0;
		if (r.operation == OP_LOAD) begin
			tbl_id[r.slot_index]     = r.task_id;
			tbl_prio[r.slot_index]   = r.priority_req;
			tbl_state[r.slot_index]  = r.run_state;
			tbl_quanta[r.slot_index] = r.quanta;
		end else begin
			best   = -1;
			best_p = 0;
			// strict compare keeps the lowest index on a tie
			for (int k = 0; k < SLOT_N; k++) begin
				if (tbl_state[k] == ST_READY && tbl_quanta[k] != 0 &&
				    int'(tbl_prio[k]) > best_p) begin
					best_p = int'(tbl_prio[k]);
					best   = k;
				end
			end
			for (int k = 0; k < SLOT_N; k++) begin
				if (k == best) begin
					tbl_prio[k]       = clamp_prio(int'(tbl_prio[k]) - int'(run_pen));
					tbl_quanta[k]     = tbl_quanta[k] - 16'd1;
					tbl_state[k]      = (tbl_quanta[k] == 0) ? ST_FINISHED : ST_READY;
					o.picked          = 1'b1;
					o.picked_slot     = 2'(k);
					o.picked_id       = tbl_id[k];
					o.picked_priority = tbl_prio[k];
					o.picked_left     = tbl_quanta[k];
				end else if (tbl_state[k] == ST_READY) begin
					tbl_prio[k] = clamp_prio(int'(tbl_prio[k]) + int'(age_step));
				end
			end
		end
		o.all_done = 1'b1;
		for (int k = 0; k < SLOT_N; k++) begin
			if (tbl_quanta[k] != 0) o.all_done = 1'b0;
		end
		return o;
	endfunction

	task automatic cmp_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
			n_errors++;
		end
	endtask

	// Drive requests from the backlog, with random gaps and occasional full drains
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fired) begin
			if (drain_hold && grant_queue.size() == 0) drain_hold = 1'b0;
			if (send_gap > 0 && !quiet) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (drain_hold || req_backlog.size() == 0) begin
				req_valid <= 1'b0;
			end else begin
				req_data  <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 15);
				if (!quiet && $urandom_range(0, 149) == 0) drain_hold = 1'b1;
			end
		end
	end

	// Stall the response side in random bursts
	always @(negedge clk) begin
		if (stall_left > 0 && !quiet) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 15) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Track config writes, check responses, predict accepted requests
	always @(posedge clk) begin
		req_fired <= req_valid && !req_stall;
		if (arst_n) begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_AGING_STEP) age_step = cfg_wdata;
				else if (cfg_index == CFG_RUN_PENALTY) run_pen = cfg_wdata;
			end
			if (rsp_valid && !rsp_stall) begin
				n_answered++;
				if (grant_queue.size() == 0) begin
					$display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
					n_errors++;
				end else begin
					want = grant_queue.pop_front();
					cmp_field("picked", want.picked, rsp_data.picked);
					cmp_field("picked_slot", want.picked_slot, rsp_data.picked_slot);
					cmp_field("picked_id", want.picked_id, rsp_data.picked_id);
					cmp_field("picked_priority", $signed(want.picked_priority),
						$signed(rsp_data.picked_priority));
					cmp_field("picked_left", want.picked_left, rsp_data.picked_left);
					cmp_field("all_done", want.all_done, rsp_data.all_done);
				end
			end
			if (req_valid && !req_stall) grant_queue.push_back(predict_grant(req_data));
		end
	end

	// Hard stop on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d responses outstanding", $time, n_issued - n_answered);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic req_t mk_req(logic op, int slot, int id, int prio, int st, int q);
		req_t r;
		r.operation    = op;
		r.slot_index   = 2'(slot);
		r.task_id      = 16'(id);
		r.priority_req = 16'(prio);
		r.run_state    = 2'(st);
		r.quanta       = 16'(q);
		return r;
	endfunction

	task automatic issue(req_t r);
		req_backlog.push_back(r);
		n_issued++;
	endtask

	// Random request; wild ones draw the run state uniformly and the priority uniformly half the time
	function automatic req_t rand_req(logic op, bit wild);
		req_t r;
		int   pv;
		r.operation  = op;
		r.slot_index = 2'($urandom_range(0, 3));
		r.task_id    = 16'($urandom);
		case ($urandom_range(0, 5))
			0: pv = int'($urandom_range(0, 65535)) - 32768;
			1: pv = int'($urandom_range(0, 16)) - 8;
			2: pv = 32767 - int'($urandom_range(0, 300));
			3: pv = -32768 + int'($urandom_range(0, 300));
			default: pv = int'($urandom_range(1, 60));
		endcase
		if (wild && $urandom_range(0, 1) == 0) pv = int'($urandom_range(0, 65535)) - 32768;
		r.priority_req = 16'(pv);
		if (wild || $urandom_range(0, 5) == 0) r.run_state = 2'($urandom_range(0, 3));
		else r.run_state = ST_READY;
		case ($urandom_range(0, 9))
			6: r.quanta = 16'd0;
			7: r.quanta = 16'($urandom);
			8: r.quanta = 16'hffff;
			9: r.quanta = 16'($urandom_range(1, 40));
			default: r.quanta = 16'($urandom_range(1, 6));
		endcase
		return r;
	endfunction

	// Mostly load-then-tick bursts, the rest noise
	task automatic queue_random(int n_items);
		int cnt;
		int nl;
		int nt;
		cnt = 0;
		while (cnt < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				nl = $urandom_range(1, 4);
				nt = $urandom_range(1, 16);
				for (int j = 0; j < nl; j++) issue(rand_req(OP_LOAD, 1'b0));
				for (int j = 0; j < nt; j++) issue(rand_req(OP_TICK, 1'b0));
				cnt += nl + nt;
			end else begin
				nl = $urandom_range(1, 6);
				for (int j = 0; j < nl; j++) issue(rand_req(logic'($urandom_range(0, 1)), 1'b1));
				cnt += nl;
			end
		end
	endtask

	task automatic wait_idle();
		while (n_answered < n_issued) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic run_phase(logic [7:0] age, logic [7:0] pen, int n_items);
		write_reg(CFG_AGING_STEP, age);
		write_reg(CFG_RUN_PENALTY, pen);
		queue_random(n_items);
		wait_idle();
	endtask

	initial begin
		slots_clear();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty tick, extremes, ties, zero priority, non-ready states, all done
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_LOAD, 0, 16'hffff, 32767, ST_READY, 2));
		issue(mk_req(OP_LOAD, 1, 0, -32768, ST_READY, 1));
		issue(mk_req(OP_LOAD, 2, 16'h1234, 100, 3, 5));
		issue(mk_req(OP_LOAD, 3, 16'haaaa, 32767, ST_READY, 0));
		issue(mk_req(OP_TICK, 3, 16'hffff, -1, 3, 16'hffff));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_LOAD, 1, 16'h5555, 7, ST_READY, 1));
		issue(mk_req(OP_LOAD, 2, 16'h00ff, 7, ST_READY, 3));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_LOAD, 0, 16'h0f0f, 0, ST_READY, 4));
		issue(mk_req(OP_LOAD, 3, 16'hf0f0, 1, ST_FINISHED, 9));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_LOAD, 2, 16'h8001, 32767, ST_INACTIVE, 16'hffff));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		for (int k = 0; k < SLOT_N; k++) issue(mk_req(OP_LOAD, k, k, -5, ST_READY, 0));
		issue(mk_req(OP_TICK, 0, 0, 0, 0, 0));
		wait_idle();

		// Register settings, extremes first
		run_phase(8'd0, 8'd0, 130);
		run_phase(8'd255, 8'd255, 130);
		run_phase(8'd0, 8'd255, 130);
		run_phase(8'd255, 8'd0, 130);
		run_phase(8'($urandom), 8'($urandom), 130);
		run_phase(8'd2, 8'd1, 130);
		run_phase(8'($urandom), 8'($urandom), 130);

		// Closing stretch at full rate
		quiet = 1'b1;
		queue_random(140);
		wait_idle();
		repeat (8) @(posedge clk);

		if (grant_queue.size() != 0) begin
			$display("%0t: %0d expected responses never arrived", $time, grant_queue.size());
			n_errors++;
		end
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
